FILE: hdl/isl_pkg.sv
// Package for the indexed shift list: operation codes, status codes, cell commands
// and the result record passed from the controller to the top level.
// Depends on nothing.
`default_nettype none

package isl_pkg;

  typedef enum logic [2:0] {
    MODE_READ      = 3'd0,
    MODE_OVERWRITE = 3'd1,
    MODE_INSERT    = 3'd2,
    MODE_REMOVE    = 3'd3,
    MODE_APPEND    = 3'd4,
    MODE_PREPEND   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_WRITE = 2'd1,
    CELL_UP    = 2'd2,
    CELL_DOWN  = 2'd3
  } cell_op_t;

  localparam int unsigned IndexWidth  = 7;
  localparam int unsigned HandleWidth = 32;

  typedef struct packed {
    status_t                 status;
    logic [IndexWidth-1:0]   position;
    logic [IndexWidth-1:0]   count;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/isl_cell.sv
// One slot of the list. It holds a single handle and, on a shift, takes the value
// of its lower or upper neighbor. Depends on isl_pkg.
`default_nettype none

module isl_cell
  import isl_pkg::*;
#(
  parameter int unsigned ENTRY_WIDTH = 32,
  parameter int unsigned POS_WIDTH   = 6,
  parameter int unsigned CELL_INDEX  = 0
) (
  input  wire logic                   clk,
  input  wire cell_op_t               op,
  input  wire logic [POS_WIDTH-1:0]   pos,
  input  wire logic [ENTRY_WIDTH-1:0] value,
  input  wire logic [ENTRY_WIDTH-1:0] lower,
  input  wire logic [ENTRY_WIDTH-1:0] upper,
  output logic      [ENTRY_WIDTH-1:0] slot
);

  localparam logic [POS_WIDTH-1:0] MyPos = POS_WIDTH'(CELL_INDEX);

  always_ff @(posedge clk) begin
    case (op)
      CELL_WRITE: begin
        if (pos == MyPos) begin
          slot <= value;
        end
      end
      CELL_UP: begin
        if (pos == MyPos) begin
          slot <= value;
        end else if (MyPos > pos) begin
          slot <= lower;
        end
      end
      CELL_DOWN: begin
        if (MyPos >= pos) begin
          slot <= upper;
        end
      end
      default: begin
        slot <= slot;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/isl_ctrl.sv
// Controller of the list: holds the live count, checks the index against it and
// turns each request into a command for the cell row and a result record.
// Depends on isl_pkg.
`default_nettype none

module isl_ctrl
  import isl_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire logic [2:0]                        mode,
  input  wire logic [IndexWidth-1:0]             index,
  output logic      [$clog2(CAPACITY+1)-1:0]     cnt,
  output cell_op_t                               cell_op,
  output logic      [$clog2(CAPACITY)-1:0]       cell_pos,
  output logic                                   rd_ok,
  output result_t                                res
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned W  = (CW > IndexWidth) ? CW : IndexWidth;

  logic [W-1:0]  idx_w;
  logic [W-1:0]  cnt_w;
  logic          full;
  logic [CW-1:0] cnt_next;
  logic [W-1:0]  cnt_next_w;
  logic [W-1:0]  pos_w;
  logic [W-1:0]  position_w;
  cell_op_t      op;
  status_t       status;

  assign idx_w      = W'(index);
  assign cnt_w      = W'(cnt);
  assign full       = (cnt_w == W'(CAPACITY));
  assign cnt_next_w = W'(cnt_next);

  always_comb begin
    op         = CELL_HOLD;
    pos_w      = '0;
    position_w = '0;
    status     = ST_OK;
    rd_ok      = 1'b0;
    cnt_next   = cnt;
    unique case (mode)
      MODE_READ: begin
        if (idx_w >= cnt_w) begin
          status = ST_BAD;
        end else begin
          rd_ok = 1'b1;
          pos_w = idx_w;
        end
      end
      MODE_OVERWRITE: begin
        if (idx_w >= cnt_w) begin
          status = ST_BAD;
        end else begin
          op         = CELL_WRITE;
          pos_w      = idx_w;
          position_w = idx_w;
        end
      end
      MODE_INSERT: begin
        if (idx_w > cnt_w) begin
          status = ST_BAD;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          op         = CELL_UP;
          pos_w      = idx_w;
          position_w = idx_w;
          cnt_next   = cnt + CW'(1);
        end
      end
      MODE_REMOVE: begin
        if (idx_w >= cnt_w) begin
          status = ST_BAD;
        end else begin
          op         = CELL_DOWN;
          pos_w      = idx_w;
          cnt_next   = cnt - CW'(1);
          position_w = W'(cnt - CW'(1));
        end
      end
      MODE_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op         = CELL_UP;
          pos_w      = cnt_w;
          position_w = cnt_w;
          cnt_next   = cnt + CW'(1);
        end
      end
      MODE_PREPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op       = CELL_UP;
          cnt_next = cnt + CW'(1);
        end
      end
      default: begin
        status = ST_BAD;
      end
    endcase
  end

  always_comb begin
    cell_op      = accept ? op : CELL_HOLD;
    cell_pos     = pos_w[PW-1:0];
    res.status   = status;
    res.position = position_w[IndexWidth-1:0];
    res.count    = cnt_next_w[IndexWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/indexed_shift_list_core.sv
// Top level of the indexed shift list: the controller, a row of slot cells and the
// result registers. Depends on isl_pkg, isl_ctrl and isl_cell.
//
// A request is a transfer on start while busy is low; busy is always low, so a
// request may be given in every cycle. It carries mode, index and entry. Exactly
// one result follows per request, in the cycle after it was taken: done is high for
// that single cycle with status, read_entry, position and count. Throughput is
// one request per cycle.
// Every slot is a cell that holds one handle; an insert, append or prepend moves
// all cells above the position up by one neighbor in the same cycle, and a remove
// moves them down by one. A read selects the addressed cell directly.
// The receiver has no way to stall results, so none are held back.
// Reset clears the live count and the done strobe; slot contents are undefined
// until written and reset does not touch them.
`default_nettype none

module indexed_shift_list_core
  import isl_pkg::*;
#(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [2:0]             mode,
  input  wire logic [IndexWidth-1:0]  index,
  input  wire logic [HandleWidth-1:0] entry,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [HandleWidth-1:0]      read_entry,
  output logic [IndexWidth-1:0]       position,
  output logic [IndexWidth-1:0]       count
);

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned PW    = $clog2(CAPACITY);
  localparam int unsigned EXT_W = (ENTRY_WIDTH > HandleWidth) ? ENTRY_WIDTH : HandleWidth;

  logic                   accept;
  logic [CW-1:0]          cnt;
  cell_op_t               cell_op;
  logic [PW-1:0]          cell_pos;
  logic                   rd_ok;
  result_t                res;
  logic [EXT_W-1:0]       entry_ext;
  logic [ENTRY_WIDTH-1:0] value;
  logic [EXT_W-1:0]       rd_ext;
  logic [ENTRY_WIDTH-1:0] slots [CAPACITY];

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign entry_ext = EXT_W'(entry);
  assign value     = entry_ext[ENTRY_WIDTH-1:0];
  assign rd_ext    = EXT_W'(slots[cell_pos]);

  isl_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .mode     (mode),
    .index    (index),
    .cnt      (cnt),
    .cell_op  (cell_op),
    .cell_pos (cell_pos),
    .rd_ok    (rd_ok),
    .res      (res)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] lower;
    logic [ENTRY_WIDTH-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = slots[i];
    end else begin : g_lower
      assign lower = slots[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper = slots[i];
    end else begin : g_upper
      assign upper = slots[i+1];
    end

    isl_cell #(
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .POS_WIDTH   (PW),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk   (clk),
      .op    (cell_op),
      .pos   (cell_pos),
      .value (value),
      .lower (lower),
      .upper (upper),
      .slot  (slots[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= res.status;
      position   <= res.position;
      count      <= res.count;
      read_entry <= rd_ok ? rd_ext[HandleWidth-1:0] : '0;
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("Accepted request did not produce a result.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("Result strobe without a request.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(CAPACITY) >= cnt)
    else $error("Live count exceeds capacity.");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> cnt == $past(cnt))
    else $error("Failed request changed the live count.");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL) |-> cnt == CW'(CAPACITY))
    else $error("Full status reported on a list that is not full.");

endmodule

`default_nettype wire

FILE: tb/indexed_shift_list_core_tb.sv
// Self-checking testbench for indexed_shift_list_core: directed, fill, drain and random
// list operations, each result compared against an in-bench list predictor.
// Depends on isl_pkg and the indexed_shift_list_core RTL.
`default_nettype none

module indexed_shift_list_core_tb;
  import isl_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned ENTRY_WIDTH = 32;
  localparam int unsigned StallLimit  = 200;
  localparam int unsigned RandomOps   = 160;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    status_t                 status;
    logic [HandleWidth-1:0]  read_entry;
    logic [IndexWidth-1:0]   position;
    logic [IndexWidth-1:0]   count;
  } list_result_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [2:0]             mode;
  logic [IndexWidth-1:0]  index;
  logic [HandleWidth-1:0] entry;
  logic                   done;
  logic [1:0]             status;
  logic [HandleWidth-1:0] read_entry;
  logic [IndexWidth-1:0]  position;
  logic [IndexWidth-1:0]  count;

  logic [HandleWidth-1:0] list_slots [0:CAPACITY-1];
  int unsigned            list_len;
  list_result_t           expected_results [$];
  list_result_t           oldest_result;
  bit                     idling_on;
  int unsigned            error_count;
  int unsigned            sent_ops;
  int unsigned            checked_results;
  int unsigned            full_hits;
  int unsigned            bad_hits;
  int unsigned            stall_cycles;

  indexed_shift_list_core #(
    .CAPACITY   (CAPACITY),
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .index     (index),
    .entry     (entry),
    .done      (done),
    .status    (status),
    .read_entry(read_entry),
    .position  (position),
    .count     (count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                 input logic [IndexWidth-1:0] idx,
                                                 input logic [HandleWidth-1:0] val);
    list_result_t res;
    res = '{status: ST_OK, read_entry: '0, position: '0, count: '0};
    case (op)
      MODE_READ: begin
        if (idx >= list_len) res.status = ST_BAD;
        else res.read_entry = list_slots[idx];
      end
      MODE_OVERWRITE: begin
        if (idx >= list_len) begin
          res.status = ST_BAD;
        end else begin
          list_slots[idx] = val;
          res.position = idx;
        end
      end
      MODE_INSERT, MODE_APPEND, MODE_PREPEND: begin
        if (op == MODE_APPEND) idx = IndexWidth'(list_len);
        if (op == MODE_PREPEND) idx = '0;
        if (idx > list_len) begin
          res.status = ST_BAD;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > idx; i--) list_slots[i] = list_slots[i-1];
          list_slots[idx] = val;
          list_len++;
          res.position = idx;
        end
      end
      MODE_REMOVE: begin
        if (idx >= list_len) begin
          res.status = ST_BAD;
        end else begin
          for (int i = idx; i + 1 < list_len; i++) list_slots[i] = list_slots[i+1];
          list_len--;
          res.position = IndexWidth'(list_len);
        end
      end
      default: res.status = ST_BAD;
    endcase
    res.count = IndexWidth'(list_len);
    return res;
  endfunction

  task automatic send_list_op(input logic [2:0] op, input logic [IndexWidth-1:0] idx,
                              input logic [HandleWidth-1:0] val);
    list_result_t res;
    @(negedge clk);
    if (idling_on && $urandom_range(99) < 33) begin
      start = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    mode  = op;
    index = idx;
    entry = val;
    start = 1'b1;
    do @(posedge clk); while (busy);
    res = apply_list_op(op, idx, val);
    if (res.status == ST_FULL) full_hits++;
    if (res.status == ST_BAD) bad_hits++;
    expected_results.push_back(res);
    sent_ops++;
  endtask

  function automatic logic [HandleWidth-1:0] pick_handle();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [IndexWidth-1:0] pick_index(input logic [2:0] op);
    if ($urandom_range(99) < 15) return IndexWidth'($urandom_range(127));
    if (op == MODE_INSERT) return IndexWidth'($urandom_range(list_len));
    if (list_len == 0) return '0;
    return IndexWidth'($urandom_range(list_len - 1));
  endfunction

  task automatic test_directed();
    send_list_op(MODE_READ, 7'd0, 32'h0);
    send_list_op(MODE_OVERWRITE, 7'd0, 32'h1234_5678);
    send_list_op(MODE_REMOVE, 7'd0, 32'h0);
    send_list_op(MODE_INSERT, 7'd1, 32'hDEAD_BEEF);
    send_list_op(MODE_INSERT, 7'd0, 32'h0000_0000);
    send_list_op(MODE_APPEND, 7'd127, 32'hFFFF_FFFF);
    send_list_op(MODE_PREPEND, 7'd64, 32'hA5A5_A5A5);
    send_list_op(MODE_INSERT, 7'd1, 32'h5A5A_5A5A);
    send_list_op(MODE_INSERT, 7'd4, 32'h8000_0001);
    send_list_op(MODE_READ, 7'd0, 32'h0);
    send_list_op(MODE_READ, 7'd1, 32'h0);
    send_list_op(MODE_READ, 7'd4, 32'h0);
    send_list_op(MODE_READ, 7'd5, 32'h0);
    send_list_op(MODE_OVERWRITE, 7'd2, 32'hFFFF_FFFF);
    send_list_op(MODE_OVERWRITE, 7'd5, 32'h1111_1111);
    send_list_op(MODE_REMOVE, 7'd1, 32'h0);
    send_list_op(MODE_REMOVE, 7'd3, 32'h0);
    send_list_op(MODE_REMOVE, 7'd64, 32'h0);
    send_list_op(MODE_READ, 7'd127, 32'h0);
    send_list_op(MODE_SPARE_LO, 7'd0, 32'hFFFF_FFFF);
    send_list_op(MODE_SPARE_HI, 7'd1, 32'hFFFF_FFFF);
    send_list_op(MODE_READ, 7'd2, 32'h0);
  endtask

  task automatic test_fill_to_capacity();
    while (list_len < CAPACITY) begin
      if ($urandom_range(1)) send_list_op(MODE_APPEND, '0, pick_handle());
      else send_list_op(MODE_PREPEND, '0, pick_handle());
    end
    send_list_op(MODE_INSERT, 7'd0, 32'hCAFE_F00D);
    send_list_op(MODE_INSERT, 7'd64, 32'hCAFE_F00D);
    send_list_op(MODE_INSERT, 7'd65, 32'hCAFE_F00D);
    send_list_op(MODE_APPEND, 7'd0, 32'hCAFE_F00D);
    send_list_op(MODE_PREPEND, 7'd0, 32'hCAFE_F00D);
    send_list_op(MODE_READ, 7'd63, 32'h0);
    send_list_op(MODE_READ, 7'd64, 32'h0);
    send_list_op(MODE_OVERWRITE, 7'd63, 32'h0F0F_0F0F);
    send_list_op(MODE_READ, 7'd63, 32'h0);
    send_list_op(MODE_REMOVE, 7'd0, 32'h0);
    send_list_op(MODE_INSERT, 7'd63, 32'h7777_7777);
    send_list_op(MODE_REMOVE, 7'd63, 32'h0);
    send_list_op(MODE_READ, 7'd62, 32'h0);
  endtask

  task automatic test_drain_to_empty();
    while (list_len > 0) send_list_op(MODE_REMOVE, pick_index(MODE_REMOVE), '0);
    send_list_op(MODE_READ, 7'd0, 32'h0);
    send_list_op(MODE_REMOVE, 7'd0, 32'h0);
  endtask

  task automatic test_random_ops();
    logic [2:0]  op;
    bit          growing;
    int unsigned r;
    growing = 1'b1;
    for (int n = 0; n < RandomOps; n++) begin
      idling_on = !(n >= 50 && n < 110);
      if (growing && list_len == CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
      if (!growing && list_len == 0 && $urandom_range(3) == 0) growing = 1'b1;
      r = $urandom_range(99);
      if (r < 15) op = MODE_READ;
      else if (r < 25) op = MODE_OVERWRITE;
      else if (r < 30) op = $urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI;
      else if (growing) begin
        if (r < 50) op = MODE_INSERT;
        else if (r < 60) op = MODE_REMOVE;
        else if (r < 80) op = MODE_APPEND;
        else op = MODE_PREPEND;
      end else begin
        if (r < 38) op = MODE_INSERT;
        else if (r < 88) op = MODE_REMOVE;
        else if (r < 94) op = MODE_APPEND;
        else op = MODE_PREPEND;
      end
      send_list_op(op, pick_index(op), pick_handle());
    end
    idling_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      checked_results++;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected: status %0d read_entry %h",
                 $time, status, read_entry);
        $display("%0t: unexpected result also has position %0d count %0d",
                 $time, position, count);
      end else begin
        oldest_result = expected_results.pop_front();
        if (status !== oldest_result.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, oldest_result.status, status);
        end
        if (read_entry !== oldest_result.read_entry) begin
          error_count++;
          $display("%0t: read_entry expected %h actual %h", $time, oldest_result.read_entry,
                   read_entry);
        end
        if (position !== oldest_result.position) begin
          error_count++;
          $display("%0t: position expected %0d actual %0d", $time, oldest_result.position,
                   position);
        end
        if (count !== oldest_result.count) begin
          error_count++;
          $display("%0t: count expected %0d actual %0d", $time, oldest_result.count, count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    start           = 1'b0;
    mode            = MODE_READ;
    index           = '0;
    entry           = '0;
    list_len        = 0;
    idling_on       = 1'b1;
    error_count     = 0;
    sent_ops        = 0;
    checked_results = 0;
    full_hits       = 0;
    bad_hits        = 0;
    stall_cycles    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_fill_to_capacity();
    test_drain_to_empty();
    test_random_ops();
    test_fill_to_capacity();
    test_drain_to_empty();

    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d list operations and checked %0d results.", sent_ops, checked_results);
    $display("Full rejections: %0d, bad-index rejections: %0d.", full_hits, bad_hits);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/isl_pkg.sv
hdl/isl_cell.sv
hdl/isl_ctrl.sv
hdl/indexed_shift_list_core.sv
tb/indexed_shift_list_core_tb.sv
